FILE: src/ssa_pkg.sv
`default_nettype none

package ssa_pkg;

    localparam int POS_W    = 31;
    localparam int DIFF_W   = 32;
    localparam int MAG_W    = 31;
    localparam int REG_W    = 32;
    localparam int OUT_W    = 32;
    localparam int D2_W     = 64;
    localparam int ROOT_W   = 32;
    localparam int QUO_W    = 32;
    localparam int CFG_IDX_W = 1;
    localparam int CNT_W    = 6;
    localparam int NUM_AXES = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DECAY = 1'b0,
        REG_ACCEL = 1'b1
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_CHK,
        ST_STR_INIT,
        ST_STR,
        ST_KMUL,
        ST_SQRT,
        ST_AMUL,
        ST_DIV,
        ST_ACC,
        ST_FIN
    } t_state;

endpackage

`default_nettype wire

FILE: src/ssa_if.sv
`default_nettype none

interface ssa_in_if;
    logic                        valid;
    logic                        ready;
    logic signed [ssa_pkg::POS_W-1:0] owner_x;
    logic signed [ssa_pkg::POS_W-1:0] owner_y;
    logic signed [ssa_pkg::POS_W-1:0] owner_z;
    logic signed [ssa_pkg::POS_W-1:0] neighbor_x;
    logic signed [ssa_pkg::POS_W-1:0] neighbor_y;
    logic signed [ssa_pkg::POS_W-1:0] neighbor_z;
    logic                        neighbor_valid;
    logic                        last_neighbor;

    modport source (output valid, owner_x, owner_y, owner_z, neighbor_x, neighbor_y,
                    neighbor_z, neighbor_valid, last_neighbor, input ready);
    modport sink (input valid, owner_x, owner_y, owner_z, neighbor_x, neighbor_y,
                  neighbor_z, neighbor_valid, last_neighbor, output ready);
endinterface

interface ssa_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [ssa_pkg::OUT_W-1:0] accel_x;
    logic signed [ssa_pkg::OUT_W-1:0] accel_y;
    logic signed [ssa_pkg::OUT_W-1:0] accel_z;
    logic                             found_any;

    modport source (output valid, accel_x, accel_y, accel_z, found_any, input ready);
    modport sink (input valid, accel_x, accel_y, accel_z, found_any, output ready);
endinterface

interface ssa_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [ssa_pkg::CFG_IDX_W-1:0]        index;
    logic [ssa_pkg::REG_W-1:0]            data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: src/separation_steering_accum.sv
// Sequence: an item without a neighbor goes straight to finish; a coincident neighbor ends
// after the check; others also run FRAC_BITS strength steps if (decay << FRAC_BITS) < d2.
// Throughput: one item at a time; the shared subtract/compare unit runs the strength
// division, a 32-step square root and three 32-step axis divisions in turn.
// Reset: synchronous active-low; clears sums, found flag, sequencer and output valid, and
// sets both registers to 1.0.
`default_nettype none

module separation_steering_accum #(
    parameter int FRAC_BITS = 16,
    parameter int ACC_WIDTH = 48
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ssa_in_if.sink    i_in,
    ssa_out_if.source o_out,
    ssa_cfg_if.sink   i_cfg
);
    import ssa_pkg::*;

    localparam int SW = ACC_WIDTH + 2;
    localparam int S_W = FRAC_BITS + 1;

    localparam logic signed [SW-1:0] ACC_HI = {{(SW-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [SW-1:0] ACC_LO = ~ACC_HI;
    localparam logic signed [SW-1:0] O_HI   = {{(SW-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    localparam logic signed [SW-1:0] O_LO   = ~O_HI;

    t_state r_state, n_state;

    logic [REG_W-1:0] r_decay, r_accel;
    logic [MAG_W-1:0] r_mag [NUM_AXES];
    logic             r_neg [NUM_AXES];
    logic             r_valid, r_last;
    logic signed [ACC_WIDTH-1:0] r_sum [NUM_AXES];
    logic             r_seen;
    logic [D2_W-1:0]  r_d2, n_d2;
    logic [63:0]      r_rem, n_rem;
    logic [63:0]      r_quo, n_quo;
    logic [63:0]      r_bit, n_bit;
    logic [63:0]      r_num, n_num;
    logic [ROOT_W-1:0] r_root, n_root;
    logic [QUO_W-1:0] r_k, n_k;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [1:0]       r_axis, n_axis;
    logic             r_oval;
    logic signed [OUT_W-1:0] r_ox, r_oy, r_oz;
    logic             r_ofound;

    logic [64:0] sub_a, sub_b;
    logic [65:0] sub_d;
    logic        sub_ge;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;

    logic accept, load_out, out_free, cnt_end;
    logic [DIFF_W-1:0] dif [NUM_AXES];
    logic signed [SW-1:0] acc_ext, term, acc_sum, acc_new;

    assign accept   = i_in.valid && i_in.ready;
    assign out_free = !r_oval || o_out.ready;
    assign load_out = (r_state == ST_FIN) && r_last && out_free;

    assign sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_ge = !sub_d[65];
    assign mul_p  = 64'(mul_a) * 64'(mul_b);

    always_comb begin
        dif[0] = {i_in.owner_x[POS_W-1], i_in.owner_x} - {i_in.neighbor_x[POS_W-1], i_in.neighbor_x};
        dif[1] = {i_in.owner_y[POS_W-1], i_in.owner_y} - {i_in.neighbor_y[POS_W-1], i_in.neighbor_y};
        dif[2] = {i_in.owner_z[POS_W-1], i_in.owner_z} - {i_in.neighbor_z[POS_W-1], i_in.neighbor_z};
    end

    always_comb begin
        case (r_state)
            ST_STR:  cnt_end = (r_cnt == CNT_W'(FRAC_BITS - 1));
            default: cnt_end = (r_cnt == CNT_W'(31));
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) n_state = i_in.neighbor_valid ? ST_SQ : ST_FIN;
            end
            ST_SQ: begin
                if (r_axis == 2'd2) n_state = ST_CHK;
            end
            ST_CHK: begin
                n_state = (r_d2 == '0) ? ST_FIN : ST_STR_INIT;
            end
            ST_STR_INIT: begin
                n_state = sub_ge ? ST_KMUL : ST_STR;
            end
            ST_STR: begin
                if (cnt_end) n_state = ST_KMUL;
            end
            ST_KMUL: n_state = ST_SQRT;
            ST_SQRT: begin
                if (cnt_end) n_state = ST_AMUL;
            end
            ST_AMUL: n_state = ST_DIV;
            ST_DIV: begin
                if (cnt_end) n_state = ST_ACC;
            end
            ST_ACC: begin
                n_state = (r_axis == 2'd2) ? ST_FIN : ST_AMUL;
            end
            ST_FIN: begin
                if (!r_last || out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        sub_a = '0;
        sub_b = '0;
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_SQ: begin
                mul_a = 32'(r_mag[r_axis]);
                mul_b = 32'(r_mag[r_axis]);
            end
            ST_STR_INIT: begin
                sub_a = 65'(r_decay) << FRAC_BITS;
                sub_b = 65'(r_d2);
            end
            ST_STR: begin
                sub_a = {r_rem, 1'b0};
                sub_b = 65'(r_d2);
            end
            ST_KMUL: begin
                mul_a = 32'(r_quo[S_W-1:0]);
                mul_b = r_accel;
            end
            ST_SQRT: begin
                sub_a = 65'(r_rem);
                sub_b = 65'(r_quo + r_bit);
            end
            ST_AMUL: begin
                mul_a = 32'(r_mag[r_axis]);
                mul_b = r_k;
            end
            ST_DIV: begin
                sub_a = 65'({r_rem[31:0], r_num[31]});
                sub_b = 65'(r_root);
            end
            default: begin
                sub_a = '0;
            end
        endcase
    end

    always_comb begin
        acc_ext = SW'(r_sum[r_axis]);
        term    = r_neg[r_axis] ? -SW'(r_quo[QUO_W-1:0]) : SW'(r_quo[QUO_W-1:0]);
        acc_sum = acc_ext + term;
        if (acc_sum > ACC_HI) begin
            acc_new = ACC_HI;
        end else if (acc_sum < ACC_LO) begin
            acc_new = ACC_LO;
        end else begin
            acc_new = acc_sum;
        end
    end

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [ACC_WIDTH-1:0] v);
        logic signed [SW-1:0] e;
        e = SW'(v);
        if (e > O_HI) begin
            sat_out = O_HI[OUT_W-1:0];
        end else if (e < O_LO) begin
            sat_out = O_LO[OUT_W-1:0];
        end else begin
            sat_out = e[OUT_W-1:0];
        end
    endfunction

    always_comb begin
        n_d2   = r_d2;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_bit  = r_bit;
        n_num  = r_num;
        n_root = r_root;
        n_k    = r_k;
        n_cnt  = r_cnt;
        n_axis = r_axis;
        case (r_state)
            ST_IDLE: begin
                n_d2   = '0;
                n_axis = '0;
            end
            ST_SQ: begin
                n_d2   = r_d2 + mul_p;
                n_axis = r_axis + 2'd1;
            end
            ST_STR_INIT: begin
                n_rem = sub_a[63:0];
                n_quo = sub_ge ? (64'd1 << FRAC_BITS) : '0;
                n_cnt = '0;
            end
            ST_STR: begin
                n_rem = sub_ge ? sub_d[63:0] : sub_a[63:0];
                n_quo = {r_quo[62:0], sub_ge};
                n_cnt = r_cnt + CNT_W'(1);
            end
            ST_KMUL: begin
                n_k   = mul_p[FRAC_BITS +: QUO_W];
                n_rem = r_d2;
                n_quo = '0;
                n_bit = 64'd1 << 62;
                n_cnt = '0;
            end
            ST_SQRT: begin
                if (sub_ge) begin
                    n_rem = sub_d[63:0];
                    n_quo = (r_quo >> 1) + r_bit;
                end else begin
                    n_quo = r_quo >> 1;
                end
                n_bit  = r_bit >> 2;
                n_cnt  = r_cnt + CNT_W'(1);
                n_root = n_quo[ROOT_W-1:0];
                n_axis = '0;
            end
            ST_AMUL: begin
                n_num = mul_p;
                n_rem = {32'd0, mul_p[63:32]};
                n_quo = '0;
                n_cnt = '0;
            end
            ST_DIV: begin
                n_rem = {32'd0, sub_ge ? sub_d[31:0] : sub_a[31:0]};
                n_num = r_num << 1;
                n_quo = {r_quo[62:0], sub_ge};
                n_cnt = r_cnt + CNT_W'(1);
            end
            ST_ACC: begin
                n_axis = r_axis + 2'd1;
            end
            default: begin
                n_cnt = r_cnt;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_decay  <= REG_W'(1) << FRAC_BITS;
            r_accel  <= REG_W'(1) << FRAC_BITS;
            r_sum[0] <= '0;
            r_sum[1] <= '0;
            r_sum[2] <= '0;
            r_seen   <= 1'b0;
            r_oval   <= 1'b0;
            r_cnt    <= '0;
            r_axis   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_axis  <= n_axis;
            if (i_cfg.valid && i_cfg.ready) begin
                case (t_reg_idx'(i_cfg.index))
                    REG_DECAY: r_decay <= i_cfg.data;
                    REG_ACCEL: r_accel <= i_cfg.data;
                    default:   r_decay <= r_decay;
                endcase
            end
            if (accept && i_in.neighbor_valid) r_seen <= 1'b1;
            if (r_state == ST_ACC) r_sum[r_axis] <= acc_new[ACC_WIDTH-1:0];
            if (load_out) begin
                r_oval   <= 1'b1;
                r_sum[0] <= '0;
                r_sum[1] <= '0;
                r_sum[2] <= '0;
                r_seen   <= 1'b0;
            end else if (o_out.ready) begin
                r_oval <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_d2   <= n_d2;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_bit  <= n_bit;
        r_num  <= n_num;
        r_root <= n_root;
        r_k    <= n_k;
        if (accept) begin
            r_valid <= i_in.neighbor_valid;
            r_last  <= i_in.last_neighbor;
            for (int a = 0; a < NUM_AXES; a++) begin
                r_neg[a] <= dif[a][DIFF_W-1];
                r_mag[a] <= dif[a][DIFF_W-1] ? MAG_W'(-dif[a]) : dif[a][MAG_W-1:0];
            end
        end
        if (load_out) begin
            r_ox     <= sat_out(r_sum[0]);
            r_oy     <= sat_out(r_sum[1]);
            r_oz     <= sat_out(r_sum[2]);
            r_ofound <= r_seen;
        end
    end

    assign i_in.ready      = (r_state == ST_IDLE);
    assign i_cfg.ready     = 1'b1;
    assign o_out.valid     = r_oval;
    assign o_out.accel_x   = r_ox;
    assign o_out.accel_y   = r_oy;
    assign o_out.accel_z   = r_oz;
    assign o_out.found_any = r_ofound;

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != ST_IDLE))
        else $error("sequencer did not leave idle after an accepted word");

    a_div_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem[63:32] == '0) && (r_rem[31:0] < r_root))
        else $error("divider remainder out of range");

    a_clear_on_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> (r_sum[0] == '0) && (r_sum[1] == '0) && (r_sum[2] == '0) && !r_seen)
        else $error("state not cleared after result");

    a_valid_only_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SQ) |-> r_valid)
        else $error("distance computed for an empty word");
`endif

endmodule

`default_nettype wire
